// ----- sv/igsp_pkg.sv -----
// ----------------------------------------------------------------------------
// igsp_pkg: shared types and constants of the gesture stroke projector
// Controller states, command and status bundles, fixed-point constants.
// ----------------------------------------------------------------------------
package igsp_pkg;

	localparam int SAMPLES_DEF = 64;
	localparam int IDX_W = 6;

	localparam logic [15:0] TIME_STEP_RST = 16'd655;
	// 0.0001 in Q.26, rounded
	localparam logic [47:0] MAG_FLOOR = 48'd6711;

	localparam logic [5:0] SQRT_STEPS_M1 = 6'd31;
	localparam logic [5:0] DIV_STEPS_M1 = 6'd62;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_FIN_MUL,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_MAG,
		ST_DIVA_INIT,
		ST_DIVA,
		ST_DIVA_END,
		ST_DIVB_INIT,
		ST_DIVB,
		ST_DIVB_END,
		ST_E_RD,
		ST_E_SUB,
		ST_E_MUL,
		ST_E_OUT
	} state_t;

	typedef struct packed {
		logic idle;
		logic take;
		logic load;
		logic fin_mul;
		logic sqrt_init;
		logic sqrt_step;
		logic mag_mul;
		logic div_init;
		logic div_step;
		logic div_end;
		logic div_b;
		logic e_rd;
		logic e_sub;
		logic e_mul;
		logic e_out;
	} cmd_t;

	typedef struct packed {
		logic last_sample;
		logic iter_zero;
		logic last_point;
		logic out_free;
	} status_t;

endpackage

// ----- sv/igsp_if.sv -----
// ----------------------------------------------------------------------------
// igsp_if: request channels of the gesture stroke projector
// Sample input, stroke point output and time step write channel.
// ----------------------------------------------------------------------------
interface igsp_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_a;
	logic signed [15:0] accel_b;
	logic signed [15:0] gyro_a;
	logic signed [15:0] gyro_b;

	modport source (output valid, output accel_a, output accel_b, output gyro_a,
		output gyro_b, input ready);
	modport sink (input valid, input accel_a, input accel_b, input gyro_a,
		input gyro_b, output ready);
endinterface

interface igsp_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] stroke_x;
	logic signed [31:0] stroke_y;
	logic [5:0] point_index;
	logic final_point;
	logic signed [31:0] least_x;
	logic signed [31:0] greatest_x;
	logic signed [31:0] least_y;
	logic signed [31:0] greatest_y;

	modport source (output valid, output stroke_x, output stroke_y, output point_index,
		output final_point, output least_x, output greatest_x, output least_y,
		output greatest_y, input ready);
	modport sink (input valid, input stroke_x, input stroke_y, input point_index,
		input final_point, input least_x, input greatest_x, input least_y,
		input greatest_y, output ready);
endinterface

interface igsp_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/igsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// igsp_ctrl: sequencer of the gesture stroke projector
// Steps the datapath through loading, square root, division and emission.
// ----------------------------------------------------------------------------
module igsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  igsp_pkg::status_t sts,
	output igsp_pkg::cmd_t    cmd
);
	import igsp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_LOAD;
			ST_LOAD:      state_d = sts.last_sample ? ST_FIN_MUL : ST_IDLE;
			ST_FIN_MUL:   state_d = ST_SQRT_INIT;
			ST_SQRT_INIT: state_d = ST_SQRT;
			ST_SQRT:      if (sts.iter_zero) state_d = ST_MAG;
			ST_MAG:       state_d = ST_DIVA_INIT;
			ST_DIVA_INIT: state_d = ST_DIVA;
			ST_DIVA:      if (sts.iter_zero) state_d = ST_DIVA_END;
			ST_DIVA_END:  state_d = ST_DIVB_INIT;
			ST_DIVB_INIT: state_d = ST_DIVB;
			ST_DIVB:      if (sts.iter_zero) state_d = ST_DIVB_END;
			ST_DIVB_END:  state_d = ST_E_RD;
			ST_E_RD:      state_d = ST_E_SUB;
			ST_E_SUB:     state_d = ST_E_MUL;
			ST_E_MUL:     state_d = ST_E_OUT;
			ST_E_OUT: begin
				if (sts.out_free) state_d = sts.last_point ? ST_IDLE : ST_E_RD;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.idle = 1'b1;
				cmd.take = in_valid;
			end
			ST_LOAD:      cmd.load = 1'b1;
			ST_FIN_MUL:   cmd.fin_mul = 1'b1;
			ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
			ST_SQRT:      cmd.sqrt_step = 1'b1;
			ST_MAG:       cmd.mag_mul = 1'b1;
			ST_DIVA_INIT: cmd.div_init = 1'b1;
			ST_DIVA:      cmd.div_step = 1'b1;
			ST_DIVA_END:  cmd.div_end = 1'b1;
			ST_DIVB_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_b = 1'b1;
			end
			ST_DIVB: begin
				cmd.div_step = 1'b1;
				cmd.div_b = 1'b1;
			end
			ST_DIVB_END: begin
				cmd.div_end = 1'b1;
				cmd.div_b = 1'b1;
			end
			ST_E_RD:      cmd.e_rd = 1'b1;
			ST_E_SUB:     cmd.e_sub = 1'b1;
			ST_E_MUL:     cmd.e_mul = 1'b1;
			ST_E_OUT:     cmd.e_out = sts.out_free;
			default:      cmd = '0;
		endcase
	end

endmodule

// ----- sv/igsp_dpath.sv -----
// ----------------------------------------------------------------------------
// igsp_dpath: datapath of the gesture stroke projector
// Integrators, orientation track memory, shared sqrt/divide unit, projection.
// ----------------------------------------------------------------------------
module igsp_dpath #(
	parameter int SAMPLES = igsp_pkg::SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  igsp_pkg::cmd_t       cmd,
	output igsp_pkg::status_t    sts,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	input  logic signed [15:0]   accel_a,
	input  logic signed [15:0]   accel_b,
	input  logic signed [15:0]   gyro_a,
	input  logic signed [15:0]   gyro_b,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic signed [31:0]   stroke_x,
	output logic signed [31:0]   stroke_y,
	output logic [igsp_pkg::IDX_W-1:0] point_index,
	output logic                 final_point,
	output logic signed [31:0]   least_x,
	output logic signed [31:0]   greatest_x,
	output logic signed [31:0]   least_y,
	output logic signed [31:0]   greatest_y
);
	import igsp_pkg::*;

	localparam int AW = $clog2(SAMPLES);

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh07FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -34'sh080000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
		logic signed [31:0] r;
		if (v > 44'sh0007FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -44'sh00080000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	logic [15:0] dt_q;
	logic signed [16:0] dt_s;
	assign dt_s = $signed({1'b0, dt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TIME_STEP_RST;
		end else if (cfg_we) begin
			dt_q <= cfg_data;
		end
	end

	// load: product of rate and time step at request, accumulate next cycle
	logic signed [15:0] acc_a_s1, acc_b_s1;
	logic signed [32:0] gp_a_s1, gp_b_s1;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			acc_a_s1 <= accel_a;
			acc_b_s1 <= accel_b;
			gp_a_s1 <= gyro_a * dt_s;
			gp_b_s1 <= gyro_b * dt_s;
		end
	end

	logic signed [23:0] asum_a_q, asum_b_q;
	logic signed [31:0] onow_a_q, onow_b_q;
	logic signed [39:0] osum_a_q, osum_b_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] pidx_q;
	logic last_point;
	logic spell_end;

	logic signed [33:0] on_sum_a, on_sum_b;
	logic signed [31:0] on_a_n, on_b_n;
	assign on_sum_a = onow_a_q + gp_a_s1;
	assign on_sum_b = onow_b_q + gp_b_s1;
	assign on_a_n = sat34(on_sum_a);
	assign on_b_n = sat34(on_sum_b);

	assign last_point = (pidx_q == AW'(SAMPLES - 1));
	assign spell_end = cmd.e_out && last_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asum_a_q <= '0;
			asum_b_q <= '0;
			onow_a_q <= '0;
			onow_b_q <= '0;
			osum_a_q <= '0;
			osum_b_q <= '0;
			cnt_q <= '0;
		end else if (spell_end) begin
			asum_a_q <= '0;
			asum_b_q <= '0;
			onow_a_q <= '0;
			onow_b_q <= '0;
			osum_a_q <= '0;
			osum_b_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			asum_a_q <= asum_a_q + acc_a_s1;
			asum_b_q <= asum_b_q + acc_b_s1;
			onow_a_q <= on_a_n;
			onow_b_q <= on_b_n;
			osum_a_q <= osum_a_q + on_a_n;
			osum_b_q <= osum_b_q + on_b_n;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// orientation track, {b, a}
	logic [63:0] track_mem [SAMPLES];
	logic [63:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) track_mem[cnt_q] <= {on_b_n, on_a_n};
		if (cmd.e_rd) rd_q <= track_mem[pidx_q];
	end

	// end of spell products
	logic signed [47:0] sqa_q, sqb_q;
	logic signed [40:0] scl_a_q, scl_b_q;
	logic signed [56:0] cp_a_q, cp_b_q;

	always_ff @(posedge clk) begin
		if (cmd.fin_mul) begin
			sqa_q <= asum_a_q * asum_a_q;
			sqb_q <= asum_b_q * asum_b_q;
			scl_a_q <= asum_a_q * dt_s;
			scl_b_q <= asum_b_q * dt_s;
			cp_a_q <= osum_a_q * dt_s;
			cp_b_q <= osum_b_q * dt_s;
		end
	end

	// centre, rounded half up
	logic signed [56:0] cr_a, cr_b;
	logic signed [41:0] ca_q, cb_q;
	assign cr_a = cp_a_q + 57'sd32768;
	assign cr_b = cp_b_q + 57'sd32768;

	// shared sqrt / divide unit
	logic [63:0] wk_q;
	logic [48:0] rem_q;
	logic [62:0] quo_q;
	logic [5:0] iter_q;
	logic [47:0] mag_q;
	logic neg_q;

	logic [43:0] sq_sum;
	logic [35:0] rem_sq, trial_sq;
	logic sq_ge;
	logic [48:0] rem_dv;
	logic dv_ge;
	logic signed [40:0] scl_sel;
	logic [40:0] scl_abs;

	assign sq_sum = sqa_q[43:0] + sqb_q[43:0];
	assign rem_sq = {rem_q[33:0], wk_q[63:62]};
	assign trial_sq = {2'b00, quo_q[31:0], 2'b01};
	assign sq_ge = (rem_sq >= trial_sq);
	assign rem_dv = {rem_q[47:0], wk_q[62]};
	assign dv_ge = (rem_dv >= {1'b0, mag_q});
	assign scl_sel = cmd.div_b ? scl_b_q : scl_a_q;
	assign scl_abs = scl_sel[40] ? 41'(-scl_sel) : 41'(scl_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.sqrt_init) begin
			iter_q <= SQRT_STEPS_M1;
		end else if (cmd.div_init) begin
			iter_q <= DIV_STEPS_M1;
		end else if ((cmd.sqrt_step || cmd.div_step) && iter_q != '0) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			wk_q <= {sq_sum, 20'd0};
			rem_q <= '0;
			quo_q <= '0;
			ca_q <= {cr_a[56], cr_a[56:16]};
			cb_q <= {cr_b[56], cr_b[56:16]};
		end else if (cmd.sqrt_step) begin
			wk_q <= {wk_q[61:0], 2'b00};
			rem_q <= {13'd0, sq_ge ? (rem_sq - trial_sq) : rem_sq};
			quo_q <= {quo_q[61:0], sq_ge};
		end else if (cmd.mag_mul) begin
			mag_q <= quo_q[31:0] * dt_q;
		end else if (cmd.div_init) begin
			if (mag_q < MAG_FLOOR) mag_q <= MAG_FLOOR;
			wk_q <= {1'b0, scl_abs[37:0], 25'd0};
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= scl_sel[40];
		end else if (cmd.div_step) begin
			wk_q <= {wk_q[62:0], 1'b0};
			rem_q <= dv_ge ? (rem_dv - {1'b0, mag_q}) : rem_dv;
			quo_q <= {quo_q[61:0], dv_ge};
		end
	end

	// direction in Q1.15, saturated
	logic [15:0] dir_n;
	logic signed [15:0] da_q, db_q;

	always_comb begin
		if (neg_q) begin
			dir_n = (quo_q > 63'd32768) ? 16'h8000 : (16'h0000 - quo_q[15:0]);
		end else begin
			dir_n = (quo_q > 63'd32767) ? 16'h7FFF : quo_q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_end) begin
			if (cmd.div_b) db_q <= $signed(dir_n);
			else da_q <= $signed(dir_n);
		end
	end

	// projection
	logic signed [41:0] na_s2, nb_s2;
	logic signed [57:0] p_aa_s3, p_bb_s3, p_ab_s3, p_ba_s3;

	always_ff @(posedge clk) begin
		if (cmd.e_sub) begin
			na_s2 <= $signed(rd_q[31:0]) - ca_q;
			nb_s2 <= $signed(rd_q[63:32]) - cb_q;
		end
		if (cmd.e_mul) begin
			p_aa_s3 <= da_q * na_s2;
			p_bb_s3 <= db_q * nb_s2;
			p_ab_s3 <= da_q * nb_s2;
			p_ba_s3 <= db_q * na_s2;
		end
	end

	logic signed [58:0] xr, yr;
	logic signed [31:0] x_n, y_n;
	logic signed [31:0] lx_q, gx_q, ly_q, gy_q;
	logic signed [31:0] lx_n, gx_n, ly_n, gy_n;

	assign xr = 59'sd16384 - p_aa_s3 - p_bb_s3;
	assign yr = 59'sd16384 + p_ab_s3 - p_ba_s3;
	assign x_n = sat44(xr[58:15]);
	assign y_n = sat44(yr[58:15]);
	assign lx_n = (x_n < lx_q) ? x_n : lx_q;
	assign gx_n = (x_n > gx_q) ? x_n : gx_q;
	assign ly_n = (y_n < ly_q) ? y_n : ly_q;
	assign gy_n = (y_n > gy_q) ? y_n : gy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q <= '0;
		end else if (cmd.div_end && cmd.div_b) begin
			pidx_q <= '0;
		end else if (cmd.e_out) begin
			pidx_q <= pidx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_end && cmd.div_b) begin
			lx_q <= 32'sh7FFFFFFF;
			gx_q <= 32'sh80000000;
			ly_q <= 32'sh7FFFFFFF;
			gy_q <= 32'sh80000000;
		end else if (cmd.e_out) begin
			lx_q <= lx_n;
			gx_q <= gx_n;
			ly_q <= ly_n;
			gy_q <= gy_n;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.e_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.e_out) begin
			stroke_x <= x_n;
			stroke_y <= y_n;
			point_index <= IDX_W'(pidx_q);
			final_point <= last_point;
			least_x <= lx_n;
			greatest_x <= gx_n;
			least_y <= ly_n;
			greatest_y <= gy_n;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.last_sample = (cnt_q == AW'(SAMPLES - 1));
	assign sts.iter_zero = (iter_q == '0);
	assign sts.last_point = last_point;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ----- sv/imu_gesture_stroke_projector.sv -----
// ----------------------------------------------------------------------------
// imu_gesture_stroke_projector: IMU spell to 2D stroke points
// Load: a sample is taken in idle and accumulated in load; no new sample is
// taken meanwhile. After the last: 32-step sqrt, two 63-step divides, then per
// point: track read, subtract, multiply, output, which waits for a free output.
// Reset clears sums, count and handshakes; time step returns to 655.
// ----------------------------------------------------------------------------
module imu_gesture_stroke_projector #(
	parameter int SAMPLES = igsp_pkg::SAMPLES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	igsp_sample_if.sink sample,
	igsp_point_if.source point,
	igsp_cfg_if.sink  cfg
);
	import igsp_pkg::*;

	cmd_t cmd;
	status_t sts;

	assign sample.ready = cmd.idle;
	assign cfg.ready = 1'b1;

	igsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	igsp_dpath #(
		.SAMPLES (SAMPLES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.accel_a     (sample.accel_a),
		.accel_b     (sample.accel_b),
		.gyro_a      (sample.gyro_a),
		.gyro_b      (sample.gyro_b),
		.out_ready   (point.ready),
		.out_valid   (point.valid),
		.stroke_x    (point.stroke_x),
		.stroke_y    (point.stroke_y),
		.point_index (point.point_index),
		.final_point (point.final_point),
		.least_x     (point.least_x),
		.greatest_x  (point.greatest_x),
		.least_y     (point.least_y),
		.greatest_y  (point.greatest_y)
	);

	a_take_load: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> cmd.load)
		else $error("accepted sample not accumulated");

	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> (point.least_x <= point.stroke_x) &&
		(point.greatest_x >= point.stroke_x) && (point.least_y <= point.stroke_y) &&
		(point.greatest_y >= point.stroke_y))
		else $error("running extremes exclude current point");

	a_final_index: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.final_point |->
		point.point_index == IDX_W'(SAMPLES - 1))
		else $error("final point at wrong index");

endmodule

// ----- dv/tb_imu_gesture_stroke_projector.sv -----
// ----------------------------------------------------------------------------
// tb_imu_gesture_stroke_projector: self-checking bench of the stroke projector
// Feeds spells of IMU samples with random gaps and back-pressure, predicts
// every stroke point in step with the accepted samples and checks each
// point field by field. Time step is rewritten between spells.
// ----------------------------------------------------------------------------
module tb_imu_gesture_stroke_projector;
	import igsp_pkg::*;

	localparam int SPELL = SAMPLES_DEF;

	typedef struct {
		logic signed [15:0] acc_a, acc_b, gyr_a, gyr_b;
	} imu_sample_t;

	typedef struct {
		logic signed [31:0] x, y;
		logic [5:0] idx;
		logic fin;
		logic signed [31:0] lx, gx, ly, gy;
	} stroke_point_t;

	logic clk;
	logic arst_n;

	igsp_sample_if sample ();
	igsp_point_if point ();
	igsp_cfg_if cfg ();

	imu_gesture_stroke_projector #(.SAMPLES(SPELL)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.point(point.source),
		.cfg(cfg.sink)
	);

	imu_sample_t samples_to_send[$];
	stroke_point_t points_due[$];
	int errors = 0;
	bit calm = 0;

	// shadow of the block state
	logic [15:0] step_reg;
	longint acc_sum_a, acc_sum_b, ori_a, ori_b, ori_sum_a, ori_sum_b;
	longint track_a[SPELL], track_b[SPELL];
	int taken;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rshift_round(longint v, int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q1.15 ratio, truncated toward zero, saturated
	function automatic longint heading(longint scaled, longint mag);
		longint m, q;
		m = scaled < 0 ? -scaled : scaled;
		q = (m <<< 25) / mag;
		if (scaled < 0) return q > 32768 ? -64'sd32768 : -q;
		return q > 32767 ? 64'sd32767 : q;
	endfunction

	task automatic project_sample(imu_sample_t s);
		longint dt, mag, da, db, ca, cb, na, nb, x, y, lx, gx, ly, gy;
		longint unsigned sq;
		stroke_point_t p;
		dt = longint'(step_reg);
		acc_sum_a += s.acc_a;
		acc_sum_b += s.acc_b;
		ori_a = clip32(ori_a + longint'(s.gyr_a) * dt);
		ori_b = clip32(ori_b + longint'(s.gyr_b) * dt);
		ori_sum_a += ori_a;
		ori_sum_b += ori_b;
		track_a[taken] = ori_a;
		track_b[taken] = ori_b;
		taken++;
		if (taken < SPELL) return;
		sq = acc_sum_a * acc_sum_a + acc_sum_b * acc_sum_b;
		mag = longint'(int_root(sq << 20)) * dt;
		if (mag < longint'(MAG_FLOOR)) mag = longint'(MAG_FLOOR);
		da = heading(acc_sum_a * dt, mag);
		db = heading(acc_sum_b * dt, mag);
		ca = rshift_round(ori_sum_a * dt, 16);
		cb = rshift_round(ori_sum_b * dt, 16);
		lx = 64'sd2147483647;
		ly = 64'sd2147483647;
		gx = -64'sd2147483648;
		gy = -64'sd2147483648;
		for (int i = 0; i < SPELL; i++) begin
			na = track_a[i] - ca;
			nb = track_b[i] - cb;
			x = clip32(rshift_round(-da * na - db * nb, 15));
			y = clip32(rshift_round(da * nb - db * na, 15));
			if (x < lx) lx = x;
			if (x > gx) gx = x;
			if (y < ly) ly = y;
			if (y > gy) gy = y;
			p.x = x[31:0];
			p.y = y[31:0];
			p.idx = i[5:0];
			p.fin = (i == SPELL - 1);
			p.lx = lx[31:0];
			p.gx = gx[31:0];
			p.ly = ly[31:0];
			p.gy = gy[31:0];
			points_due.push_back(p);
		end
		acc_sum_a = 0; acc_sum_b = 0;
		ori_a = 0; ori_b = 0;
		ori_sum_a = 0; ori_sum_b = 0;
		taken = 0;
	endtask

	// sample driver
	int send_gap = 0;
	bit offered = 0;

	always @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			project_sample(samples_to_send.pop_front());
			offered = 0;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !offered) begin
			if (send_gap > 0) begin
				send_gap--;
				sample.valid <= 1'b0;
			end else if (samples_to_send.size() > 0) begin
				sample.accel_a <= samples_to_send[0].acc_a;
				sample.accel_b <= samples_to_send[0].acc_b;
				sample.gyro_a <= samples_to_send[0].gyr_a;
				sample.gyro_b <= samples_to_send[0].gyr_b;
				sample.valid <= 1'b1;
				offered = 1;
				send_gap = calm ? 0 : $urandom_range(0, 12);
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// point monitor and back-pressure
	int hold = 0;

	always @(posedge clk) begin
		stroke_point_t e;
		if (point.valid && point.ready) begin
			hold = calm ? 0 : $urandom_range(0, 12);
			if (points_due.size() == 0) begin
				$display("%0t: unexpected point idx %0d x %0d y %0d", $time,
					point.point_index, point.stroke_x, point.stroke_y);
				errors++;
			end else begin
				e = points_due.pop_front();
				if (point.stroke_x !== e.x || point.stroke_y !== e.y
						|| point.point_index !== e.idx || point.final_point !== e.fin
						|| point.least_x !== e.lx || point.greatest_x !== e.gx
						|| point.least_y !== e.ly || point.greatest_y !== e.gy) begin
					$display("%0t: point mismatch expected x %0d y %0d idx %0d fin %0d",
						$time, e.x, e.y, e.idx, e.fin);
					$display("    min/max x %0d %0d y %0d %0d", e.lx, e.gx, e.ly, e.gy);
					$display("  actual x %0d y %0d idx %0d fin %0d", point.stroke_x,
						point.stroke_y, point.point_index, point.final_point);
					$display("    min/max x %0d %0d y %0d %0d", point.least_x,
						point.greatest_x, point.least_y, point.greatest_y);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold > 0) begin
			hold--;
			point.ready <= 1'b0;
		end else begin
			point.ready <= 1'b1;
		end
	end

	function automatic logic [15:0] pick_value(int mode);
		case (mode)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_sample(logic [15:0] a, logic [15:0] b, logic [15:0] ga,
			logic [15:0] gb);
		imu_sample_t s;
		s.acc_a = a;
		s.acc_b = b;
		s.gyr_a = ga;
		s.gyr_b = gb;
		samples_to_send.push_back(s);
	endtask

	task automatic add_random(int n);
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			if (mode < 3)
				add_sample(pick_value($urandom_range(0, 3)), pick_value($urandom_range(0, 3)),
					pick_value($urandom_range(0, 3)), pick_value($urandom_range(0, 3)));
			else
				add_sample(pick_value(3), pick_value(3), pick_value(3), pick_value(3));
		end
	endtask

	// wait for every point, then let the block settle
	task automatic drain();
		while (samples_to_send.size() > 0 || offered || points_due.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_step(logic [15:0] v);
		@(negedge clk);
		cfg.data <= v;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		step_reg = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		arst_n = 0;
		sample.valid = 0;
		sample.accel_a = 0;
		sample.accel_b = 0;
		sample.gyro_a = 0;
		sample.gyro_b = 0;
		point.ready = 0;
		cfg.valid = 0;
		cfg.data = 0;
		step_reg = TIME_STEP_RST;
		acc_sum_a = 0; acc_sum_b = 0;
		ori_a = 0; ori_b = 0;
		ori_sum_a = 0; ori_sum_b = 0;
		taken = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset time step, zero acceleration over the spell hits the clamp
		for (int i = 0; i < SPELL; i++)
			add_sample(16'h0000, 16'h0000, pick_value($urandom_range(0, 3)), pick_value(3));
		drain();

		// widest step: orientation saturates, acceleration sums at the extremes
		write_step(16'hFFFF);
		calm = 1;
		for (int i = 0; i < SPELL; i++)
			add_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
		drain();

		// narrowest step: tiny magnitude
		write_step(16'h0001);
		calm = 0;
		add_sample(16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000);
		for (int i = 1; i < SPELL; i++)
			add_sample(16'h0000, 16'h0000, pick_value($urandom_range(0, 3)), pick_value(3));
		drain();

		write_step(16'($urandom_range(1, 65535)));
		add_random(SPELL);
		drain();

		if (errors == 0)
			$display("** imu_gesture_stroke_projector: PASSED **");
		else
			$display("** imu_gesture_stroke_projector: FAILED **");
		$finish;
	end

	initial begin
		#3000000;
		$display("** imu_gesture_stroke_projector: FAILED **");
		$finish;
	end

endmodule
